// ----- src/cfle_pkg.sv -----
// ----------------------------------------------------------------------------
// Credit flow link endpoint package
// Shared sizes, codes and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cfle_pkg;

  // Sizes of the receive FIFO and of the transmit credit.
  localparam int FIFO_DEPTH     = 64;
  localparam int INITIAL_CREDIT = 64;
  localparam int PTR_W          = $clog2(FIFO_DEPTH);
  localparam int CNT_W          = $clog2(FIFO_DEPTH + 1);
  localparam int CRED_W         = $clog2(INITIAL_CREDIT + 1);

  // Field widths.
  localparam int KIND_W  = 2;
  localparam int LEN_W   = 11;
  localparam int MAC_W   = 48;
  localparam int TYPE_W  = 16;
  localparam int WORD_W  = 64;
  localparam int STAT_W  = 3;
  localparam int REQ_W   = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_ETYPE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_CODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_CODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 3'd4;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_FRAME = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK           = 3'd0;
  localparam logic [STAT_W-1:0] STAT_IGNORED      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_RX_OVERFLOW  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_CREDIT_OVF   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_READ_EMPTY   = 3'd4;
  localparam logic [STAT_W-1:0] STAT_NO_CREDIT    = 3'd5;
  localparam logic [STAT_W-1:0] STAT_UNKNOWN_TYPE = 3'd6;

  // Send request codes.
  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DATA  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TOKEN = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;   // latch the accepted request
    logic rd_issue;  // read the FIFO head from the store
    logic commit;    // update state and load the result register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic pop;       // the held request dequeues a word
    logic slot_free; // the result register can take a new result
  } sts_t;

endpackage

`default_nettype wire

// ----- src/credit_flow_link_endpoint_top.sv -----
// ----------------------------------------------------------------------------
// Credit flow link endpoint
// Frame filter, receive FIFO and transmit credit counter of a one-word-per-
// frame link, with host read and write requests.
//
//   Channel  Handshake             Direction  Payload
//   in_      in_valid / in_ready   request    kind, frame, MAC, types, word
//   out_     out_valid / out_ready result     status, send request, words
//   cfg_     cfg_we                write      index, 48-bit data
//
// A request is captured in the idle state and committed from the execute
// state, which loads its result into the output register. A host read that
// dequeues a word passes through a data wait state before its commit, since
// the word store has a registered read port. One request is in flight at a
// time; the next is accepted while the previous result waits in the output
// register. A stalled output holds the commit of the following request. Reset
// is synchronous; the word store has no clearing pass, as no entry is read
// before it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module credit_flow_link_endpoint_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration
  input  wire logic                            cfg_we,
  input  wire logic [cfle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cfle_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Request channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [cfle_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [cfle_pkg::LEN_W-1:0]      in_frame_length,
  input  wire logic [cfle_pkg::MAC_W-1:0]      in_dest_mac,
  input  wire logic [cfle_pkg::TYPE_W-1:0]     in_etype,
  input  wire logic [cfle_pkg::TYPE_W-1:0]     in_ptype,
  input  wire logic [cfle_pkg::WORD_W-1:0]     in_data_word,
  // Result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [cfle_pkg::STAT_W-1:0]     out_status,
  output logic      [cfle_pkg::REQ_W-1:0]      out_send_request,
  output logic      [cfle_pkg::WORD_W-1:0]     out_send_word,
  output logic                                 out_read_valid,
  output logic      [cfle_pkg::WORD_W-1:0]     out_read_word
);

  import cfle_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller.
  cfle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  cfle_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_kind          (in_kind),
    .in_frame_length  (in_frame_length),
    .in_dest_mac      (in_dest_mac),
    .in_etype         (in_etype),
    .in_ptype         (in_ptype),
    .in_data_word     (in_data_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_send_request (out_send_request),
    .out_send_word    (out_send_word),
    .out_read_valid   (out_read_valid),
    .out_read_word    (out_read_word),
    .cmd              (cmd),
    .sts              (sts)
  );

  // A dequeued word always comes with a token request and an ok status.
  a_read_token : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_read_valid) |->
      (out_status == STAT_OK && out_send_request == REQ_TOKEN))
    else $error("dequeued word without token request");

  // A data frame request never carries a dequeued word.
  a_data_req : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_send_request == REQ_DATA) |->
      (out_status == STAT_OK && !out_read_valid))
    else $error("data frame request with bad status");

  // Only one request is in flight: no acceptance right after another.
  a_one_inflight : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  // A store read is always followed by a wait, never by a new request.
  a_read_wait : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |=> (!in_ready && !cmd.rd_issue))
    else $error("store read not followed by the data wait");

endmodule

`default_nettype wire

// ----- src/cfle_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfle_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/cfle_ctrl.sv -----
// ----------------------------------------------------------------------------
// Credit flow link endpoint controller
// Sequences one request at a time: capture, optional store read, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module cfle_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cfle_pkg::sts_t sts,
  output cfle_pkg::cmd_t     cmd
);

  import cfle_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_RDATA = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.pop) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_RDATA;
        end else if (sts.slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_RDATA: begin
        if (sts.slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/cfle_dp.sv -----
// ----------------------------------------------------------------------------
// Credit flow link endpoint datapath
// Configuration registers, request holding register, frame decode, FIFO
// pointers, credit counter, receive store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfle_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration
  input  wire logic                            cfg_we,
  input  wire logic [cfle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cfle_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Request payload
  input  wire logic [cfle_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [cfle_pkg::LEN_W-1:0]      in_frame_length,
  input  wire logic [cfle_pkg::MAC_W-1:0]      in_dest_mac,
  input  wire logic [cfle_pkg::TYPE_W-1:0]     in_etype,
  input  wire logic [cfle_pkg::TYPE_W-1:0]     in_ptype,
  input  wire logic [cfle_pkg::WORD_W-1:0]     in_data_word,
  // Result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [cfle_pkg::STAT_W-1:0]     out_status,
  output logic      [cfle_pkg::REQ_W-1:0]      out_send_request,
  output logic      [cfle_pkg::WORD_W-1:0]     out_send_word,
  output logic                                 out_read_valid,
  output logic      [cfle_pkg::WORD_W-1:0]     out_read_word,
  // Controller link
  input  wire cfle_pkg::cmd_t                  cmd,
  output cfle_pkg::sts_t                       sts
);

  import cfle_pkg::*;

  // Configuration registers.
  logic [MAC_W-1:0]  own_mac_r;
  logic [TYPE_W-1:0] link_etype_r;
  logic [TYPE_W-1:0] token_code_r;
  logic [TYPE_W-1:0] data_code_r;
  logic [LEN_W-1:0]  frame_len_cfg_r;

  // Held request.
  logic [KIND_W-1:0] kind_r;
  logic [LEN_W-1:0]  flen_r;
  logic [MAC_W-1:0]  mac_r;
  logic [TYPE_W-1:0] etype_r;
  logic [TYPE_W-1:0] ptype_r;
  logic [WORD_W-1:0] word_r;

  // FIFO and credit state.
  logic [PTR_W-1:0]  wptr_r;
  logic [PTR_W-1:0]  rptr_r;
  logic [CNT_W-1:0]  count_r;
  logic [CRED_W-1:0] credit_r;
  logic [WORD_W-1:0] ram_rdata;

  // Result register.
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [REQ_W-1:0]  out_req_r;
  logic [WORD_W-1:0] out_send_word_r;
  logic              out_read_valid_r;
  logic [WORD_W-1:0] out_read_word_r;

  // Decode outcome.
  logic              frame_match;
  logic [STAT_W-1:0] res_status;
  logic [REQ_W-1:0]  res_req;
  logic              do_inc;
  logic              do_dec;
  logic              do_push;
  logic              do_pop;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r       <= '0;
      link_etype_r    <= '0;
      token_code_r    <= '0;
      data_code_r     <= '0;
      frame_len_cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_MAC:      own_mac_r       <= cfg_wdata;
        CFG_LINK_ETYPE:   link_etype_r    <= cfg_wdata[TYPE_W-1:0];
        CFG_TOKEN_CODE:   token_code_r    <= cfg_wdata[TYPE_W-1:0];
        CFG_DATA_CODE:    data_code_r     <= cfg_wdata[TYPE_W-1:0];
        CFG_FRAME_LENGTH: frame_len_cfg_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Request holding register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      flen_r  <= in_frame_length;
      mac_r   <= in_dest_mac;
      etype_r <= in_etype;
      ptype_r <= in_ptype;
      word_r  <= in_data_word;
    end
  end

  assign frame_match = (flen_r == frame_len_cfg_r) && (mac_r == own_mac_r) &&
                       (etype_r == link_etype_r);

  // Outcome of the held request against the current state.
  always_comb begin
    res_status = STAT_IGNORED;
    res_req    = REQ_NONE;
    do_inc     = 1'b0;
    do_dec     = 1'b0;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    case (kind_r)
      KIND_FRAME: begin
        if (!frame_match) begin
          res_status = STAT_IGNORED;
        end else if (ptype_r == token_code_r) begin
          // A token code wins when both codes are equal.
          if (credit_r >= CRED_W'(INITIAL_CREDIT)) begin
            res_status = STAT_CREDIT_OVF;
          end else begin
            res_status = STAT_OK;
            do_inc     = 1'b1;
          end
        end else if (ptype_r == data_code_r) begin
          if (count_r >= CNT_W'(FIFO_DEPTH)) begin
            res_status = STAT_RX_OVERFLOW;
          end else begin
            res_status = STAT_OK;
            do_push    = 1'b1;
          end
        end else begin
          res_status = STAT_UNKNOWN_TYPE;
        end
      end
      KIND_READ: begin
        if (count_r == '0) begin
          res_status = STAT_READ_EMPTY;
        end else begin
          res_status = STAT_OK;
          res_req    = REQ_TOKEN;
          do_pop     = 1'b1;
        end
      end
      KIND_WRITE: begin
        if (credit_r == '0) begin
          res_status = STAT_NO_CREDIT;
        end else begin
          res_status = STAT_OK;
          res_req    = REQ_DATA;
          do_dec     = 1'b1;
        end
      end
      default: begin
        res_status = STAT_IGNORED;
      end
    endcase
  end

  // Pointers, word count and credit, updated on commit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r   <= '0;
      rptr_r   <= '0;
      count_r  <= '0;
      credit_r <= CRED_W'(INITIAL_CREDIT);
    end else if (cmd.commit) begin
      if (do_push) begin
        wptr_r  <= (wptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
        count_r <= count_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r  <= (rptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
        count_r <= count_r - 1'b1;
      end
      if (do_inc) begin
        credit_r <= credit_r + 1'b1;
      end
      if (do_dec) begin
        credit_r <= credit_r - 1'b1;
      end
    end
  end

  // Receive word store.
  cfle_ram #(
    .WIDTH (WORD_W),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.commit & do_push),
    .waddr (wptr_r),
    .wdata (word_r),
    .re    (cmd.rd_issue),
    .raddr (rptr_r),
    .rdata (ram_rdata)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r     <= res_status;
      out_req_r        <= res_req;
      out_send_word_r  <= (res_req == REQ_DATA) ? word_r : '0;
      out_read_valid_r <= do_pop;
      out_read_word_r  <= do_pop ? ram_rdata : '0;
    end
  end

  assign sts.pop       = do_pop;
  assign sts.slot_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_send_request = out_req_r;
  assign out_send_word    = out_send_word_r;
  assign out_read_valid   = out_read_valid_r;
  assign out_read_word    = out_read_word_r;

endmodule

`default_nettype wire
